// ===== hw/rtl/windowed_draw_cooccurrence_counter_assert.svh =====
// Assertion macros shared by the windowed draw co-occurrence counter RTL.
`ifndef WINDOWED_DRAW_COOCCURRENCE_COUNTER_ASSERT_SVH
`define WINDOWED_DRAW_COOCCURRENCE_COUNTER_ASSERT_SVH
`ifndef SYNTHESIS
`define WDCC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("wdcc assertion failed");
`define WDCC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wdcc assertion failed");
`else
`define WDCC_ASSERT(lbl, prop)
`define WDCC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/wdcc_pkg.sv =====
// Package: types, constants and helpers of the windowed draw co-occurrence counter.
package wdcc_pkg;

    localparam int DRAW_SIZE  = 5;
    localparam int DS_W       = 3;
    localparam int NUM_VALUES = 11;
    localparam int VAL_W      = 4;
    localparam int CNT_W      = 10;
    localparam int LEN_W      = 8;
    localparam int IDX_W      = 3;
    localparam int ADDR_W     = 1 + 2 * VAL_W;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;

    typedef logic [DRAW_SIZE-1:0][VAL_W-1:0] draw_t;

    typedef enum logic [1:0] {
        REQ_PUSH = 2'd0,
        REQ_NUM  = 2'd1,
        REQ_PAIR = 2'd2,
        REQ_NONE = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        CMD_RD,
        CMD_INC,
        CMD_DEC,
        CMD_CLR
    } cmd_kind_t;

    typedef struct packed {
        logic              en;
        cmd_kind_t         kind;
        logic [ADDR_W-1:0] addr;
    } lane_cmd_t;

    typedef enum logic [1:0] {
        RESP_ZERO,
        RESP_NUM,
        RESP_PAIR
    } resp_kind_t;

    typedef struct packed {
        logic             valid;
        logic             status;
        resp_kind_t       kind;
        logic [IDX_W-1:0] win;
    } resp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_WRITE,
        ST_CLEAR,
        ST_RC_RD,
        ST_UPD,
        ST_QUERY,
        ST_RESP
    } state_t;

    typedef enum logic [1:0] {
        PASS_ADD,
        PASS_SUB,
        PASS_RCNT
    } pass_t;

    function automatic logic valid_num(input logic [VAL_W-1:0] v);
        return (v >= VAL_W'(1)) && (v <= VAL_W'(NUM_VALUES));
    endfunction

    function automatic logic [ADDR_W-1:0] num_addr(input logic [VAL_W-1:0] x);
        return {1'b0, {VAL_W{1'b0}}, x};
    endfunction

    function automatic logic [ADDR_W-1:0] pair_addr(input logic [VAL_W-1:0] x,
                                                    input logic [VAL_W-1:0] y);
        return {1'b1, x, y};
    endfunction

    function automatic logic [LEN_W-1:0] len_reset(input int w);
        logic [LEN_W-1:0] r;
        unique case (w)
            0:       r = LEN_W'(5);
            1:       r = LEN_W'(10);
            2:       r = LEN_W'(30);
            3:       r = LEN_W'(50);
            default: r = LEN_W'(100);
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/wdcc_lane.sv =====
// One window lane: number and pair count memory with read-modify-write.
module wdcc_lane (
    input  logic                     clk,
    input  logic                     rst_n,
    input  wdcc_pkg::lane_cmd_t      cmd,
    output logic [wdcc_pkg::CNT_W-1:0] rd_data
);
    import wdcc_pkg::*;

    localparam int MEM_DEPTH = 1 << ADDR_W;

    logic [CNT_W-1:0]  mem [MEM_DEPTH];
    logic [CNT_W-1:0]  rd_data_reg;
    logic [ADDR_W-1:0] rmw_addr_reg;
    logic              rmw_dec_reg;
    logic              rmw_pend_reg;
    logic [CNT_W-1:0]  upd_val;

    // counts never reach the top code with the supported window lengths
    assign upd_val = rmw_dec_reg ? (rd_data_reg - CNT_W'(1)) : (rd_data_reg + CNT_W'(1));
    assign rd_data = rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.en && cmd.kind == CMD_CLR)
        begin
            mem[cmd.addr] <= '0;
        end
        else if (rmw_pend_reg)
        begin
            mem[rmw_addr_reg] <= upd_val;
        end
        if (cmd.en && cmd.kind != CMD_CLR)
        begin
            rd_data_reg <= mem[cmd.addr];
        end
        rmw_addr_reg <= cmd.addr;
        rmw_dec_reg  <= (cmd.kind == CMD_DEC);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rmw_pend_reg <= 1'b0;
        end
        else
        begin
            rmw_pend_reg <= cmd.en && (cmd.kind == CMD_INC || cmd.kind == CMD_DEC);
        end
    end

endmodule

// ===== hw/rtl/wdcc_merge.sv =====
// Merge stage: picks the lane answer and holds the result register.
module wdcc_merge #(
    parameter int NUM_WINDOWS = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wdcc_pkg::resp_t               resp,
    output logic                          resp_ready,
    input  logic [wdcc_pkg::CNT_W-1:0]    lane_rd [NUM_WINDOWS],
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [wdcc_pkg::OUT_DATA_W-1:0] m_tdata
);
    import wdcc_pkg::*;

    localparam int WSEL_W = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;

    logic             out_valid_reg;
    logic             status_reg;
    logic [CNT_W-1:0] ncount_reg;
    logic [CNT_W-1:0] pcount_reg;
    logic [CNT_W-1:0] sel_cnt;
    logic             load;

    assign resp_ready = !out_valid_reg || m_tready;
    assign load       = resp.valid && resp_ready;
    assign sel_cnt    = lane_rd[resp.win[WSEL_W-1:0]];

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= resp.status;
            ncount_reg <= (resp.kind == RESP_NUM)  ? sel_cnt : '0;
            pcount_reg <= (resp.kind == RESP_PAIR) ? sel_cnt : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_DATA_W - 1 - 2 * CNT_W)'(0), pcount_reg, ncount_reg, status_reg};

endmodule

// ===== hw/rtl/wdcc_ctrl.sv =====
// Sequencer: request decode, draw history, window lengths and lane commands.
`include "windowed_draw_cooccurrence_counter_assert.svh"
module wdcc_ctrl #(
    parameter int HISTORY_DEPTH = 128,
    parameter int NUM_WINDOWS   = 5
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [wdcc_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic [1:0]                     s_tuser,
    input  logic                           cfg_we,
    input  logic [wdcc_pkg::IDX_W-1:0]     cfg_index,
    input  logic [wdcc_pkg::LEN_W-1:0]     cfg_data,
    output wdcc_pkg::lane_cmd_t            cmd [NUM_WINDOWS],
    output wdcc_pkg::resp_t                resp,
    input  logic                           resp_ready
);
    import wdcc_pkg::*;

    localparam int D      = HISTORY_DEPTH;
    localparam int HW     = (D > 1) ? $clog2(D) : 1;
    localparam int CW     = $clog2(D + 1);
    localparam int WSEL_W = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;

    state_t            state_reg, state_next;
    pass_t             pass_reg;
    logic              tog_reg;
    logic [WSEL_W-1:0] wcnt_reg;
    logic [DS_W-1:0]   i_reg, j_reg;
    logic [CW-1:0]     k_reg;
    logic [ADDR_W-1:0] clr_reg;
    logic [HW-1:0]     head_reg;
    logic [CW-1:0]     stored_reg;
    logic              dirty_reg;
    logic              live_reg;
    logic [LEN_W-1:0]  len_reg [NUM_WINDOWS];

    draw_t             hist [D];
    draw_t             hist_rd_reg;
    draw_t             new_draw_reg;
    draw_t             rc_draw_reg;
    draw_t             old_draw_reg [NUM_WINDOWS];
    logic              leave_reg [NUM_WINDOWS];
    logic [VAL_W-1:0]  qa_reg, qb_reg;
    logic              resp_status_reg;
    resp_kind_t        resp_kind_reg;
    logic [IDX_W-1:0]  resp_win_reg;

    // request fields
    draw_t             in_draw;
    logic [IDX_W-1:0]  in_win;
    logic [VAL_W-1:0]  in_qa, in_qb;
    req_t              in_req;
    logic              draw_ok, win_ok, q_ok, accept;

    logic [CW-1:0]     eff [NUM_WINDOWS];
    logic [HW:0]       leave_sum, rc_sum;
    logic [HW-1:0]     hist_raddr;
    logic              hist_re;
    logic              ij_last;
    logic [NUM_WINDOWS-1:0] cmd_en_vec;

    assign in_draw = draw_t'(s_tdata[DRAW_SIZE*VAL_W-1:0]);
    assign in_win  = s_tdata[22:20];
    assign in_qa   = s_tdata[26:23];
    assign in_qb   = s_tdata[30:27];
    assign in_req  = req_t'(s_tuser);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        draw_ok = 1'b1;
        for (int n = 0; n < DRAW_SIZE; n++)
        begin
            if (!valid_num(in_draw[n]))
            begin
                draw_ok = 1'b0;
            end
        end
    end

    assign win_ok = ({1'b0, in_win} < (IDX_W + 1)'(NUM_WINDOWS));
    assign q_ok   = valid_num(in_qa) && ((in_req != REQ_PAIR) || valid_num(in_qb));

    // effective window length, capped at the history depth
    always_comb
    begin
        for (int w = 0; w < NUM_WINDOWS; w++)
        begin
            eff[w] = (int'(len_reg[w]) > D) ? CW'(D) : CW'(len_reg[w]);
        end
    end

    // slot of the draw leaving window wcnt, and of the k-th newest draw
    always_comb
    begin
        leave_sum = {1'b0, head_reg} + (HW + 1)'(D) - (HW + 1)'(eff[wcnt_reg]);
        if (leave_sum >= (HW + 1)'(D))
        begin
            leave_sum = leave_sum - (HW + 1)'(D);
        end
        rc_sum = {1'b0, head_reg} + (HW + 1)'(D - 1) - (HW + 1)'(k_reg);
        if (rc_sum >= (HW + 1)'(D))
        begin
            rc_sum = rc_sum - (HW + 1)'(D);
        end
    end

    assign hist_re    = ((state_reg == ST_FETCH) || (state_reg == ST_RC_RD)) && !tog_reg;
    assign hist_raddr = (state_reg == ST_FETCH) ? leave_sum[HW-1:0] : rc_sum[HW-1:0];
    assign ij_last    = (i_reg == DS_W'(DRAW_SIZE - 1)) && (j_reg == DS_W'(DRAW_SIZE - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    unique case (in_req)
                        REQ_PUSH:
                        begin
                            if (!draw_ok)
                                state_next = ST_RESP;
                            else if (dirty_reg)
                                state_next = ST_WRITE;
                            else
                                state_next = ST_FETCH;
                        end
                        REQ_NUM, REQ_PAIR:
                        begin
                            state_next = (win_ok && q_ok && live_reg) ? ST_QUERY : ST_RESP;
                        end
                        default: state_next = ST_RESP;
                    endcase
                end
            end
            ST_FETCH:
            begin
                if (tog_reg && wcnt_reg == WSEL_W'(NUM_WINDOWS - 1))
                    state_next = ST_WRITE;
            end
            ST_WRITE: state_next = dirty_reg ? ST_CLEAR : ST_UPD;
            ST_CLEAR:
            begin
                if (&clr_reg)
                    state_next = ST_RC_RD;
            end
            ST_RC_RD:
            begin
                if (tog_reg)
                    state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (tog_reg && ij_last)
                begin
                    unique case (pass_reg)
                        PASS_ADD: state_next = ST_UPD;
                        PASS_SUB: state_next = ST_RESP;
                        default:
                        begin
                            state_next = (k_reg == stored_reg - CW'(1)) ? ST_RESP : ST_RC_RD;
                        end
                    endcase
                end
            end
            ST_QUERY: state_next = ST_RESP;
            ST_RESP:
            begin
                if (resp_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // lane commands and response
    always_comb
    begin
        draw_t            d;
        logic [VAL_W-1:0] x, y;
        for (int w = 0; w < NUM_WINDOWS; w++)
        begin
            cmd[w].en   = 1'b0;
            cmd[w].kind = CMD_INC;
            cmd[w].addr = '0;
            d = new_draw_reg;
            x = '0;
            y = '0;
            unique case (state_reg)
                ST_CLEAR:
                begin
                    cmd[w].en   = 1'b1;
                    cmd[w].kind = CMD_CLR;
                    cmd[w].addr = clr_reg;
                end
                ST_QUERY:
                begin
                    cmd[w].en   = 1'b1;
                    cmd[w].kind = CMD_RD;
                    cmd[w].addr = (resp_kind_reg == RESP_PAIR) ? pair_addr(qa_reg, qb_reg)
                                                               : num_addr(qa_reg);
                end
                ST_UPD:
                begin
                    unique case (pass_reg)
                        PASS_ADD:
                        begin
                            d = new_draw_reg;
                            cmd[w].en = (eff[w] != '0);
                        end
                        PASS_SUB:
                        begin
                            d = old_draw_reg[w];
                            cmd[w].en   = leave_reg[w];
                            cmd[w].kind = CMD_DEC;
                        end
                        default:
                        begin
                            d = rc_draw_reg;
                            cmd[w].en = (k_reg < eff[w]);
                        end
                    endcase
                    x = d[i_reg];
                    y = d[j_reg];
                    if (i_reg == j_reg)
                    begin
                        cmd[w].addr = num_addr(x);
                    end
                    else
                    begin
                        cmd[w].addr = pair_addr(x, y);
                        cmd[w].en   = cmd[w].en && (x != y);
                    end
                    cmd[w].en = cmd[w].en && !tog_reg;
                end
                default:
                begin
                    cmd[w].en = 1'b0;
                end
            endcase
            cmd_en_vec[w] = cmd[w].en;
        end
        resp.valid  = (state_reg == ST_RESP);
        resp.status = resp_status_reg;
        resp.kind   = resp_kind_reg;
        resp.win    = resp_win_reg;
    end

    // history ring
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WRITE)
        begin
            hist[head_reg] <= new_draw_reg;
        end
        if (hist_re)
        begin
            hist_rd_reg <= hist[hist_raddr];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            new_draw_reg  <= in_draw;
            qa_reg        <= in_qa;
            qb_reg        <= in_qb;
            resp_win_reg  <= in_win;
            resp_status_reg <= 1'b0;
            resp_kind_reg   <= RESP_ZERO;
            if (in_req == REQ_PUSH)
            begin
                resp_status_reg <= !draw_ok;
            end
            else if ((in_req == REQ_NUM || in_req == REQ_PAIR) && win_ok)
            begin
                resp_status_reg <= !q_ok;
                if (q_ok && live_reg)
                    resp_kind_reg <= (in_req == REQ_NUM) ? RESP_NUM : RESP_PAIR;
            end
        end
        if (state_reg == ST_FETCH && tog_reg)
        begin
            old_draw_reg[wcnt_reg] <= hist_rd_reg;
            leave_reg[wcnt_reg]    <= (stored_reg >= eff[wcnt_reg]) && (eff[wcnt_reg] != '0);
        end
        if (state_reg == ST_RC_RD && tog_reg)
        begin
            rc_draw_reg <= hist_rd_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pass_reg   <= PASS_ADD;
            tog_reg    <= 1'b0;
            wcnt_reg   <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
            clr_reg    <= '0;
            head_reg   <= '0;
            stored_reg <= '0;
            dirty_reg  <= 1'b1;
            live_reg   <= 1'b0;
            for (int w = 0; w < NUM_WINDOWS; w++)
            begin
                len_reg[w] <= len_reset(w);
            end
        end
        else
        begin
            state_reg <= state_next;
            tog_reg   <= (state_reg == ST_FETCH || state_reg == ST_RC_RD ||
                          state_reg == ST_UPD) ? !tog_reg : 1'b0;

            if (cfg_we && ({1'b0, cfg_index} < (IDX_W + 1)'(NUM_WINDOWS)))
            begin
                len_reg[cfg_index[WSEL_W-1:0]] <= cfg_data;
                dirty_reg <= 1'b1;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    wcnt_reg <= '0;
                    pass_reg <= PASS_ADD;
                    i_reg    <= '0;
                    j_reg    <= '0;
                end
                ST_FETCH:
                begin
                    if (tog_reg)
                        wcnt_reg <= wcnt_reg + WSEL_W'(1);
                end
                ST_WRITE:
                begin
                    head_reg <= (head_reg == HW'(D - 1)) ? '0 : head_reg + HW'(1);
                    if (stored_reg != CW'(D))
                        stored_reg <= stored_reg + CW'(1);
                    live_reg <= 1'b1;
                    if (dirty_reg)
                    begin
                        dirty_reg <= 1'b0;
                        pass_reg  <= PASS_RCNT;
                        k_reg     <= '0;
                        clr_reg   <= '0;
                    end
                end
                ST_CLEAR: clr_reg <= clr_reg + ADDR_W'(1);
                ST_UPD:
                begin
                    if (tog_reg)
                    begin
                        if (j_reg == DS_W'(DRAW_SIZE - 1))
                        begin
                            j_reg <= '0;
                            i_reg <= (i_reg == DS_W'(DRAW_SIZE - 1)) ? '0 : i_reg + DS_W'(1);
                        end
                        else
                        begin
                            j_reg <= j_reg + DS_W'(1);
                        end
                        if (ij_last)
                        begin
                            if (pass_reg == PASS_ADD)
                                pass_reg <= PASS_SUB;
                            else if (pass_reg == PASS_RCNT)
                                k_reg <= k_reg + CW'(1);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    `WDCC_ASSERT(a_head_range, head_reg <= HW'(D - 1))
    `WDCC_ASSERT(a_stored_range, stored_reg <= CW'(D))
    `WDCC_ASSERT(a_no_cmd_idle, (state_reg == ST_IDLE) |-> (cmd_en_vec == '0))
    `WDCC_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

endmodule

// ===== hw/rtl/windowed_draw_cooccurrence_counter.sv =====
// A rejected push or trivial read goes straight to the result register; a count read first reads
// the lanes. An accepted push fetches each leaving draw, writes the new draw, then does at most one
// read-modify-write per lane and slot: 25 slots for the new draw and 25 for the leaving one. After a
// window length write the next push instead clears the lane memories and recounts each stored draw.
// Throughput: one transfer at a time; the sequencer takes the next one after the result loads.
// Reset: async active low; lengths to 5/10/30/50/100, history empty, counts read as zero.
module windowed_draw_cooccurrence_counter #(
    parameter int HISTORY_DEPTH = 128,
    parameter int NUM_WINDOWS   = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // draw_a, draw_b, draw_c, draw_d, draw_e, window_sel, query_first, query_second, pad
    input  logic [31:0] s_tdata,
    // req_type
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status, number_count, pair_count, pad
    output logic [23:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import wdcc_pkg::*;

    lane_cmd_t        cmd [NUM_WINDOWS];
    logic [CNT_W-1:0] lane_rd [NUM_WINDOWS];
    resp_t            resp;
    logic             resp_ready;

    wdcc_ctrl #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .NUM_WINDOWS   (NUM_WINDOWS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .resp       (resp),
        .resp_ready (resp_ready)
    );

    // one lane per window; all lanes step through the same draw slots together
    for (genvar w = 0; w < NUM_WINDOWS; w++)
    begin : g_lane
        wdcc_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd[w]),
            .rd_data (lane_rd[w])
        );
    end

    wdcc_merge #(
        .NUM_WINDOWS (NUM_WINDOWS)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .resp       (resp),
        .resp_ready (resp_ready),
        .lane_rd    (lane_rd),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
